// File: design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: design/aips_pkg.sv
`default_nettype none

package aips_pkg;

   // Event kinds
   typedef enum logic [1:0] {
      KIND_START     = 2'd0,
      KIND_DATA_RDY  = 2'd1,
      KIND_BUS_EVENT = 2'd2,
      KIND_BUS_ERROR = 2'd3
   } kind_type;

   // Sequence steps
   typedef enum logic [3:0] {
      SQ_IDLE    = 4'd0,
      SQ_C1_ZERO = 4'd1,
      SQ_C3_ZERO = 4'd2,
      SQ_C3_SET  = 4'd3,
      SQ_C1_SET  = 4'd4,
      SQ_READ_X  = 4'd5,
      SQ_READ_Y  = 4'd6,
      SQ_READ_Z  = 4'd7
   } step_type;

   // Bus phases of a read transfer
   localparam logic [2:0] RD_PH_SB    = 3'd0;
   localparam logic [2:0] RD_PH_ADDR  = 3'd1;
   localparam logic [2:0] RD_PH_BTF   = 3'd2;
   localparam logic [2:0] RD_PH_RSB   = 3'd3;
   localparam logic [2:0] RD_PH_RADDR = 3'd4;
   localparam logic [2:0] RD_PH_RXNE  = 3'd5;

   // Bus phases of a write transfer
   localparam logic [2:0] WR_PH_SB    = 3'd0;
   localparam logic [2:0] WR_PH_ADDR  = 3'd1;
   localparam logic [2:0] WR_PH_TXE   = 3'd2;
   localparam logic [2:0] WR_PH_BTF   = 3'd3;

   // Accelerometer register addresses
   localparam logic [7:0] ACC_CTRL1 = 8'h20;
   localparam logic [7:0] ACC_CTRL3 = 8'h22;
   localparam logic [7:0] ACC_OUT_X = 8'h29;
   localparam logic [7:0] ACC_OUT_Y = 8'h2B;
   localparam logic [7:0] ACC_OUT_Z = 8'h2D;

   // Configuration registers
   localparam int          CSR_INDEX_W = 2;
   localparam int          CSR_DATA_W  = 8;
   localparam logic [1:0]  CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [1:0]  CSR_CTRL1_INIT     = 2'd1;
   localparam logic [1:0]  CSR_CTRL3_INIT     = 2'd2;
   localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'h1C;
   localparam logic [7:0]  CTRL1_INIT_RST     = 8'b01000111;
   localparam logic [7:0]  CTRL3_INIT_RST     = 8'b00000100;

   typedef struct packed {
      logic [6:0] device_address;
      logic [7:0] ctrl1_init;
      logic [7:0] ctrl3_init;
   } cfg_type;

   typedef struct packed {
      kind_type        kind;
      logic            flag_sb;
      logic            flag_addr;
      logic            flag_btf;
      logic            flag_txe;
      logic            flag_rxne;
      logic signed [7:0] rx_byte;
      logic            int_line_high;
   } req_type;

   typedef struct packed {
      logic       dr_write;
      logic [7:0] dr_byte;
      logic       send_start;
      logic       send_stop;
      logic       clear_ack;
      logic       led_update;
      logic [1:0] led_axis;
      logic [7:0] led_level;
      logic       watchdog_kick;
      logic       system_reset;
   } rsp_type;

   typedef struct packed {
      logic [2:0] bus_phase;
      logic       is_read;
      logic [7:0] target_register;
      logic [7:0] write_value;
      step_type   step;
      logic       ready_pending;
   } seq_state_type;

   localparam seq_state_type SEQ_STATE_RST = '{
      bus_phase:       3'd0,
      is_read:         1'b0,
      target_register: 8'd0,
      write_value:     8'd0,
      step:            SQ_IDLE,
      ready_pending:   1'b0
   };

endpackage

`default_nettype wire

// File: design/accel_i2c_poll_sequencer.sv
// Event-driven I2C master sequencer for a three-axis accelerometer.
// Request channel (req_*): one event per request - start-up, data ready,
// bus status flags or bus error - with the status flags, received byte
// and interrupt line level. Response channel (rsp_*): exactly one response
// per request carrying the bus action (data register byte, start, stop,
// ack clear), an LED level for each received axis, watchdog kick and
// system reset request.
// Pipeline: two register stages, the request register, where a request is
// decided, then the response register.
// Throughput: one request per cycle unless the response side stalls; each
// decision is a single pass of the phase/step logic against the sequencer
// state register.
// Stall: while rsp_ready is low the response register holds; one more
// request is held in the request register, then req_ready drops.
// Reset clears the sequencer to idle, empties both stages and loads the
// configuration defaults (address 0x1C, CTRL1 0x47, CTRL3 0x04).
// csr_* writes are registered and should only be made while idle.
`default_nettype none
`include "assert_macros.svh"

module accel_i2c_poll_sequencer
   import aips_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   // request channel
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [1:0]             req_kind,
   input  wire logic                   req_flag_sb,
   input  wire logic                   req_flag_addr,
   input  wire logic                   req_flag_btf,
   input  wire logic                   req_flag_txe,
   input  wire logic                   req_flag_rxne,
   input  wire logic signed [7:0]      req_rx_byte,
   input  wire logic                   req_int_line_high,
   // response channel
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_dr_write,
   output      logic [7:0]             rsp_dr_byte,
   output      logic                   rsp_send_start,
   output      logic                   rsp_send_stop,
   output      logic                   rsp_clear_ack,
   output      logic                   rsp_led_update,
   output      logic [1:0]             rsp_led_axis,
   output      logic [7:0]             rsp_led_level,
   output      logic                   rsp_watchdog_kick,
   output      logic                   rsp_system_reset
);

   cfg_type cfg;
   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_comb;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    advance;
   logic    req_take;

   aips_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // Held request moves on when the response register is free or draining
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   // Request register
   always_comb begin
      req_in.kind          = kind_type'(req_kind);
      req_in.flag_sb       = req_flag_sb;
      req_in.flag_addr     = req_flag_addr;
      req_in.flag_btf      = req_flag_btf;
      req_in.flag_txe      = req_flag_txe;
      req_in.flag_rxne     = req_flag_rxne;
      req_in.rx_byte       = req_rx_byte;
      req_in.int_line_high = req_int_line_high;
   end

   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   aips_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .go    (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (rsp_comb)
   );

   // Response register
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_comb;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dr_write      = rsp_ff.dr_write;
   assign rsp_dr_byte       = rsp_ff.dr_byte;
   assign rsp_send_start    = rsp_ff.send_start;
   assign rsp_send_stop     = rsp_ff.send_stop;
   assign rsp_clear_ack     = rsp_ff.clear_ack;
   assign rsp_led_update    = rsp_ff.led_update;
   assign rsp_led_axis      = rsp_ff.led_axis;
   assign rsp_led_level     = rsp_ff.led_level;
   assign rsp_watchdog_kick = rsp_ff.watchdog_kick;
   assign rsp_system_reset  = rsp_ff.system_reset;

   // Checks
   `ASSERT_IMP(a_err_alone, clock, reset, rsp_valid && rsp_system_reset,
               !rsp_watchdog_kick && !rsp_dr_write && !rsp_send_start &&
               !rsp_send_stop && !rsp_led_update)
   `ASSERT_IMP(a_led_kick, clock, reset, rsp_valid && rsp_led_update,
               rsp_watchdog_kick && (rsp_led_axis != 2'd3))
   `ASSERT_IMP(a_byte_zero, clock, reset, rsp_valid && !rsp_dr_write, rsp_dr_byte == 8'd0)
   `ASSERT_IMP(a_full_stall, clock, reset, req_valid_ff && rsp_valid && !rsp_ready, !req_ready)
   `ASSERT_NXT(a_take_shows, clock, reset, advance, rsp_valid)

endmodule

`default_nettype wire

// File: design/aips_csr.sv
`default_nettype none

module aips_csr
   import aips_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   output      cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wr_data[6:0];
            CSR_CTRL1_INIT:     cfg_in.ctrl1_init     = csr_wr_data;
            CSR_CTRL3_INIT:     cfg_in.ctrl3_init     = csr_wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEVICE_ADDRESS_RST;
         cfg_ff.ctrl1_init     <= CTRL1_INIT_RST;
         cfg_ff.ctrl3_init     <= CTRL3_INIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: design/aips_ctrl.sv
`default_nettype none

module aips_ctrl
   import aips_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic go,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output      rsp_type rsp
);

   seq_state_type st_ff;
   seq_state_type st_in;
   logic [7:0]    addr_byte;
   logic          idle;
   logic          hit;
   logic [3:0]    axis_diff;

   // Load a transfer for a sequence step, starting at the first phase
   function automatic seq_state_type begin_xfer(input seq_state_type s,
                                                input step_type nxt,
                                                input cfg_type c);
      seq_state_type r;
      r           = s;
      r.step      = nxt;
      r.bus_phase = 3'd0;
      unique case (nxt)
         SQ_C1_ZERO: begin
            r.is_read = 1'b0; r.target_register = ACC_CTRL1; r.write_value = 8'd0;
         end
         SQ_C3_ZERO: begin
            r.is_read = 1'b0; r.target_register = ACC_CTRL3; r.write_value = 8'd0;
         end
         SQ_C3_SET: begin
            r.is_read = 1'b0; r.target_register = ACC_CTRL3; r.write_value = c.ctrl3_init;
         end
         SQ_C1_SET: begin
            r.is_read = 1'b0; r.target_register = ACC_CTRL1; r.write_value = c.ctrl1_init;
         end
         SQ_READ_X: begin
            r.is_read = 1'b1; r.target_register = ACC_OUT_X;
         end
         SQ_READ_Y: begin
            r.is_read = 1'b1; r.target_register = ACC_OUT_Y;
         end
         default: begin
            r.is_read = 1'b1; r.target_register = ACC_OUT_Z;
         end
      endcase
      return r;
   endfunction

   assign addr_byte = {cfg.device_address, 1'b0};
   assign idle      = (st_ff.step == SQ_IDLE);
   assign axis_diff = 4'(st_ff.step) - 4'(SQ_READ_X);

   // Next state and result for one request
   always_comb begin
      st_in = st_ff;
      rsp   = '0;
      hit   = 1'b0;
      unique case (req.kind)
         KIND_START: begin
            st_in.ready_pending = 1'b0;
            st_in = begin_xfer(st_in, SQ_C1_ZERO, cfg);
            rsp.send_start = 1'b1;
         end
         KIND_DATA_RDY: begin
            if (idle) begin
               st_in = begin_xfer(st_ff, SQ_READ_X, cfg);
               rsp.send_start = 1'b1;
            end else begin
               st_in.ready_pending = 1'b1;
            end
         end
         KIND_BUS_ERROR: begin
            st_in = SEQ_STATE_RST;
            rsp.system_reset = 1'b1;
         end
         default: begin
            if (!idle && st_ff.is_read) begin
               // read transfer: address, register, repeated start, single byte
               unique case (st_ff.bus_phase)
                  RD_PH_SB: if (req.flag_sb) begin
                     hit = 1'b1; rsp.dr_write = 1'b1; rsp.dr_byte = addr_byte;
                  end
                  RD_PH_ADDR: if (req.flag_addr) begin
                     hit = 1'b1; rsp.dr_write = 1'b1; rsp.dr_byte = st_ff.target_register;
                  end
                  RD_PH_BTF: if (req.flag_btf) begin
                     hit = 1'b1; rsp.send_start = 1'b1;
                  end
                  RD_PH_RSB: if (req.flag_sb) begin
                     hit = 1'b1; rsp.dr_write = 1'b1;
                     rsp.dr_byte = addr_byte | 8'd1; rsp.clear_ack = 1'b1;
                  end
                  RD_PH_RADDR: if (req.flag_addr) begin
                     hit = 1'b1; rsp.send_stop = 1'b1;
                  end
                  RD_PH_RXNE: if (req.flag_rxne) begin
                     hit = 1'b1;
                  end
                  default: hit = 1'b0;
               endcase
               if (hit) begin
                  rsp.watchdog_kick = 1'b1;
                  if (st_ff.bus_phase != RD_PH_RXNE) begin
                     st_in.bus_phase = st_ff.bus_phase + 3'd1;
                  end else begin
                     // byte in hand: drive the LED, then next axis, a new X read or finish
                     rsp.led_update = 1'b1;
                     rsp.led_axis   = axis_diff[1:0];
                     rsp.led_level  = req.rx_byte[7] ? 8'(-req.rx_byte)
                                                     : 8'(req.rx_byte);
                     st_in.bus_phase = 3'd0;
                     priority if (st_ff.step == SQ_READ_X) begin
                        st_in = begin_xfer(st_in, SQ_READ_Y, cfg);
                        rsp.send_start = 1'b1;
                     end else if (st_ff.step == SQ_READ_Y) begin
                        st_in = begin_xfer(st_in, SQ_READ_Z, cfg);
                        rsp.send_start = 1'b1;
                     end else if (req.int_line_high || st_ff.ready_pending) begin
                        st_in.ready_pending = 1'b0;
                        st_in = begin_xfer(st_in, SQ_READ_X, cfg);
                        rsp.send_start = 1'b1;
                     end else begin
                        st_in.step = SQ_IDLE;
                     end
                  end
               end
            end else if (!idle) begin
               // write transfer: address, register, value, stop
               unique case (st_ff.bus_phase)
                  WR_PH_SB: if (req.flag_sb) begin
                     hit = 1'b1; rsp.dr_write = 1'b1; rsp.dr_byte = addr_byte;
                  end
                  WR_PH_ADDR: if (req.flag_addr) begin
                     hit = 1'b1; rsp.dr_write = 1'b1; rsp.dr_byte = st_ff.target_register;
                  end
                  WR_PH_TXE: if (req.flag_txe) begin
                     hit = 1'b1; rsp.dr_write = 1'b1; rsp.dr_byte = st_ff.write_value;
                  end
                  WR_PH_BTF: if (req.flag_btf) begin
                     hit = 1'b1; rsp.send_stop = 1'b1;
                  end
                  default: hit = 1'b0;
               endcase
               if (hit) begin
                  rsp.watchdog_kick = 1'b1;
                  if (st_ff.bus_phase != WR_PH_BTF) begin
                     st_in.bus_phase = st_ff.bus_phase + 3'd1;
                  end else begin
                     st_in.bus_phase = 3'd0;
                     priority if (st_ff.step == SQ_C1_ZERO) begin
                        st_in = begin_xfer(st_in, SQ_C3_ZERO, cfg);
                        rsp.send_start = 1'b1;
                     end else if (st_ff.step == SQ_C3_ZERO) begin
                        st_in = begin_xfer(st_in, SQ_C3_SET, cfg);
                        rsp.send_start = 1'b1;
                     end else if (st_ff.step == SQ_C3_SET) begin
                        st_in = begin_xfer(st_in, SQ_C1_SET, cfg);
                        rsp.send_start = 1'b1;
                     end else if (req.int_line_high || st_ff.ready_pending) begin
                        st_in.ready_pending = 1'b0;
                        st_in = begin_xfer(st_in, SQ_READ_X, cfg);
                        rsp.send_start = 1'b1;
                     end else begin
                        st_in.step = SQ_IDLE;
                     end
                  end
               end
            end
         end
      endcase
   end

   // Sequencer state advances once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= SEQ_STATE_RST;
      end else if (go) begin
         st_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

// File: test/tb.sv
`default_nettype none

module tb;
   import aips_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   // clock, reset and block inputs, all known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_valid = 1'b0;
   req_type                req_drv = '0;
   logic                   rsp_ready = 1'b0;

   wire logic       req_ready;
   wire logic       rsp_valid;
   wire logic       rsp_dr_write;
   wire logic [7:0] rsp_dr_byte;
   wire logic       rsp_send_start;
   wire logic       rsp_send_stop;
   wire logic       rsp_clear_ack;
   wire logic       rsp_led_update;
   wire logic [1:0] rsp_led_axis;
   wire logic [7:0] rsp_led_level;
   wire logic       rsp_watchdog_kick;
   wire logic       rsp_system_reset;

   // sequencer model: configuration and state
   logic [6:0] cfg_addr;
   logic [7:0] cfg_ctrl1;
   logic [7:0] cfg_ctrl3;
   logic [2:0] cur_phase;
   logic       cur_is_read;
   logic [7:0] cur_target;
   logic [7:0] cur_wr_value;
   step_type   cur_step;
   logic       cur_pending;

   rsp_type expected_rsp_q[$];

   // run bookkeeping
   int  failures = 0;
   int  cycle_count = 0;
   int  rsp_checked = 0;
   int  requests_sent = 0;
   int  kind_count[4] = '{0, 0, 0, 0};
   int  led_levels = 0;
   int  wd_kicks = 0;
   int  csr_writes = 0;
   bit  quiet = 1'b0;
   int  hold_off = 0;
   int  ready_gap = 0;

   accel_i2c_poll_sequencer dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_drv.kind),
      .req_flag_sb       (req_drv.flag_sb),
      .req_flag_addr     (req_drv.flag_addr),
      .req_flag_btf      (req_drv.flag_btf),
      .req_flag_txe      (req_drv.flag_txe),
      .req_flag_rxne     (req_drv.flag_rxne),
      .req_rx_byte       (req_drv.rx_byte),
      .req_int_line_high (req_drv.int_line_high),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dr_write      (rsp_dr_write),
      .rsp_dr_byte       (rsp_dr_byte),
      .rsp_send_start    (rsp_send_start),
      .rsp_send_stop     (rsp_send_stop),
      .rsp_clear_ack     (rsp_clear_ack),
      .rsp_led_update    (rsp_led_update),
      .rsp_led_axis      (rsp_led_axis),
      .rsp_led_level     (rsp_led_level),
      .rsp_watchdog_kick (rsp_watchdog_kick),
      .rsp_system_reset  (rsp_system_reset)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Sequencer model
   // ---------------------------------------------------------------

   function automatic void clear_sequencer();
      cur_phase    = '0;
      cur_is_read  = 1'b0;
      cur_target   = '0;
      cur_wr_value = '0;
      cur_step     = SQ_IDLE;
      cur_pending  = 1'b0;
   endfunction

   // set up the register transfer for a step; caller raises send_start
   function automatic void load_transfer(step_type s);
      cur_step  = s;
      cur_phase = '0;
      case (s)
         SQ_C1_ZERO: begin
            cur_is_read = 1'b0; cur_target = ACC_CTRL1; cur_wr_value = 8'd0;
         end
         SQ_C3_ZERO: begin
            cur_is_read = 1'b0; cur_target = ACC_CTRL3; cur_wr_value = 8'd0;
         end
         SQ_C3_SET: begin
            cur_is_read = 1'b0; cur_target = ACC_CTRL3; cur_wr_value = cfg_ctrl3;
         end
         SQ_C1_SET: begin
            cur_is_read = 1'b0; cur_target = ACC_CTRL1; cur_wr_value = cfg_ctrl1;
         end
         SQ_READ_X: begin
            cur_is_read = 1'b1; cur_target = ACC_OUT_X;
         end
         SQ_READ_Y: begin
            cur_is_read = 1'b1; cur_target = ACC_OUT_Y;
         end
         default: begin
            cur_is_read = 1'b1; cur_target = ACC_OUT_Z;
         end
      endcase
   endfunction

   // end of start-up or of the Z read; returns 1 when a new X read begins
   function automatic bit end_sequence(logic line_high);
      if (line_high || cur_pending) begin
         cur_pending = 1'b0;
         load_transfer(SQ_READ_X);
         return 1'b1;
      end
      cur_step  = SQ_IDLE;
      cur_phase = '0;
      return 1'b0;
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type    o;
      logic [7:0] addr_byte;
      logic [7:0] level;
      bit         idle;
      bit         hit;
      o         = '0;
      addr_byte = {cfg_addr, 1'b0};
      idle      = (cur_step == SQ_IDLE) || (cur_step > SQ_READ_Z);
      hit       = 1'b0;
      level     = r.rx_byte;
      if (r.rx_byte < 0)
         level = -r.rx_byte;
      case (r.kind)
         KIND_START: begin
            cur_pending = 1'b0;
            load_transfer(SQ_C1_ZERO);
            o.send_start = 1'b1;
         end
         KIND_DATA_RDY: begin
            if (idle) begin
               load_transfer(SQ_READ_X);
               o.send_start = 1'b1;
            end else
               cur_pending = 1'b1;
         end
         KIND_BUS_ERROR: begin
            clear_sequencer();
            o.system_reset = 1'b1;
         end
         KIND_BUS_EVENT: begin
            if (!idle && cur_is_read) begin
               case (cur_phase)
                  RD_PH_SB: if (r.flag_sb) begin
                     hit = 1'b1; o.dr_write = 1'b1; o.dr_byte = addr_byte;
                  end
                  RD_PH_ADDR: if (r.flag_addr) begin
                     hit = 1'b1; o.dr_write = 1'b1; o.dr_byte = cur_target;
                  end
                  RD_PH_BTF: if (r.flag_btf) begin
                     hit = 1'b1; o.send_start = 1'b1;
                  end
                  RD_PH_RSB: if (r.flag_sb) begin
                     hit = 1'b1; o.dr_write = 1'b1; o.dr_byte = addr_byte | 8'd1;
                     o.clear_ack = 1'b1;
                  end
                  RD_PH_RADDR: if (r.flag_addr) begin
                     hit = 1'b1; o.send_stop = 1'b1;
                  end
                  RD_PH_RXNE: if (r.flag_rxne)
                     hit = 1'b1;
                  default: hit = 1'b0;
               endcase
               if (hit) begin
                  o.watchdog_kick = 1'b1;
                  if (cur_phase < RD_PH_RXNE)
                     cur_phase = cur_phase + 3'd1;
                  else begin
                     // byte received: deliver the axis level, move to next axis or end the sequence
                     o.led_update = 1'b1;
                     o.led_axis   = 2'(cur_step - SQ_READ_X);
                     o.led_level  = level;
                     cur_phase    = '0;
                     if (cur_step == SQ_READ_X) begin
                        load_transfer(SQ_READ_Y);
                        o.send_start = 1'b1;
                     end else if (cur_step == SQ_READ_Y) begin
                        load_transfer(SQ_READ_Z);
                        o.send_start = 1'b1;
                     end else
                        o.send_start = end_sequence(r.int_line_high);
                  end
               end
            end else if (!idle) begin
               case (cur_phase)
                  WR_PH_SB: if (r.flag_sb) begin
                     hit = 1'b1; o.dr_write = 1'b1; o.dr_byte = addr_byte;
                  end
                  WR_PH_ADDR: if (r.flag_addr) begin
                     hit = 1'b1; o.dr_write = 1'b1; o.dr_byte = cur_target;
                  end
                  WR_PH_TXE: if (r.flag_txe) begin
                     hit = 1'b1; o.dr_write = 1'b1; o.dr_byte = cur_wr_value;
                  end
                  WR_PH_BTF: if (r.flag_btf) begin
                     hit = 1'b1; o.send_stop = 1'b1;
                  end
                  default: hit = 1'b0;
               endcase
               if (hit) begin
                  o.watchdog_kick = 1'b1;
                  if (cur_phase < WR_PH_BTF)
                     cur_phase = cur_phase + 3'd1;
                  else begin
                     cur_phase = '0;
                     if (cur_step < SQ_C1_SET) begin
                        load_transfer(step_type'(cur_step + 4'd1));
                        o.send_start = 1'b1;
                     end else
                        o.send_start = end_sequence(r.int_line_high);
                  end
               end
            end
         end
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (quiet)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // random content; for bus events the flag the current phase waits on is forced
   function automatic req_type make_request(kind_type k, bit good);
      req_type r;
      r.kind          = k;
      r.flag_sb       = 1'($urandom_range(0, 1));
      r.flag_addr     = 1'($urandom_range(0, 1));
      r.flag_btf      = 1'($urandom_range(0, 1));
      r.flag_txe      = 1'($urandom_range(0, 1));
      r.flag_rxne     = 1'($urandom_range(0, 1));
      r.rx_byte       = 8'($urandom_range(0, 255));
      r.int_line_high = ($urandom_range(0, 99) < 35);
      if (k == KIND_BUS_EVENT) begin
         if (cur_is_read) begin
            case (cur_phase)
               RD_PH_SB, RD_PH_RSB:     r.flag_sb   = good;
               RD_PH_ADDR, RD_PH_RADDR: r.flag_addr = good;
               RD_PH_BTF:               r.flag_btf  = good;
               default:                 r.flag_rxne = good;
            endcase
         end else begin
            case (cur_phase)
               WR_PH_SB:   r.flag_sb   = good;
               WR_PH_ADDR: r.flag_addr = good;
               WR_PH_TXE:  r.flag_txe  = good;
               default:    r.flag_btf  = good;
            endcase
         end
      end
      return r;
   endfunction

   // offer one request, hold it until accepted, then log what it should produce
   task automatic send_request(req_type r);
      int      gap;
      rsp_type pred;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_drv   <= r;
      do
         @(posedge clock);
      while (!req_ready);
      pred = predict_response(r);
      expected_rsp_q.push_back(pred);
      requests_sent++;
      kind_count[r.kind]++;
      if (pred.led_update)
         led_levels++;
      if (pred.watchdog_kick)
         wd_kicks++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_DEVICE_ADDRESS: cfg_addr  = data[6:0];
         CSR_CTRL1_INIT:     cfg_ctrl1 = data;
         CSR_CTRL3_INIT:     cfg_ctrl3 = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // idle cases, pending data ready, wrong flag, sample extremes, abort, error
   task automatic test_directed();
      req_type r;
      int      i;
      send_request(make_request(KIND_BUS_EVENT, 1'b1));
      send_request(make_request(KIND_DATA_RDY, 1'b1));
      send_request(make_request(KIND_DATA_RDY, 1'b1));
      send_request(make_request(KIND_BUS_EVENT, 1'b0));
      // X gets -128, Y 127, Z 0; pending data ready restarts X with line low
      for (i = 0; i < 18; i++) begin
         r = make_request(KIND_BUS_EVENT, 1'b1);
         r.rx_byte = (i < 6) ? 8'sh80 : (i < 12) ? 8'sh7F : 8'sh00;
         r.int_line_high = 1'b0;
         send_request(r);
      end
      send_request(make_request(KIND_START, 1'b1));
      send_request(make_request(KIND_BUS_ERROR, 1'b1));
      send_request(make_request(KIND_BUS_EVENT, 1'b1));
   endtask

   // long receiver hold while requests keep coming back to back
   task automatic test_backpressure();
      int i;
      quiet    = 1'b1;
      hold_off = 300;
      send_request(make_request(KIND_START, 1'b1));
      for (i = 0; i < 40; i++)
         send_request(make_request(kind_type'(cur_step == SQ_IDLE ? KIND_DATA_RDY
                                                                  : KIND_BUS_EVENT),
                                   1'b1));
      quiet = 1'b0;
   endtask

   // mostly well-formed bus steps, some wrong flags, restarts, errors and noise
   task automatic test_random_traffic(int count);
      int       i;
      int       roll;
      kind_type k;
      bit       good;
      for (i = 0; i < count; i++) begin
         if (i % 120 == 0)
            quiet = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         good = 1'b1;
         if (cur_step == SQ_IDLE) begin
            if (roll < 55)
               k = KIND_DATA_RDY;
            else if (roll < 85)
               k = KIND_START;
            else if (roll < 95)
               k = KIND_BUS_EVENT;
            else
               k = KIND_BUS_ERROR;
         end else begin
            if (roll < 80)
               k = KIND_BUS_EVENT;
            else if (roll < 88) begin
               k    = KIND_BUS_EVENT;
               good = 1'b0;
            end else if (roll < 93)
               k = KIND_DATA_RDY;
            else if (roll < 96)
               k = KIND_START;
            else if (roll < 98)
               k = KIND_BUS_ERROR;
            else begin
               k    = kind_type'($urandom_range(0, 3));
               good = 1'($urandom_range(0, 1));
            end
         end
         send_request(make_request(k, good));
      end
      quiet = 1'b0;
   endtask

   // several register settings, extremes included, each followed by a start-up
   task automatic test_config_sweep();
      logic [7:0] a;
      logic [7:0] c1;
      logic [7:0] c3;
      int         n;
      for (n = 0; n < 5; n++) begin
         case (n)
            0: begin a = 8'h00; c1 = 8'h00; c3 = 8'h00; end
            1: begin a = 8'hFF; c1 = 8'hFF; c3 = 8'hFF; end
            2: begin a = 8'h7F; c1 = 8'hA5; c3 = 8'h5A; end
            default: begin
               a  = 8'($urandom_range(0, 255));
               c1 = 8'($urandom_range(0, 255));
               c3 = 8'($urandom_range(0, 255));
            end
         endcase
         wait_for_drain();
         write_csr(CSR_DEVICE_ADDRESS, a);
         write_csr(CSR_CTRL1_INIT, c1);
         write_csr(CSR_CTRL3_INIT, c3);
         send_request(make_request(KIND_START, 1'b1));
         test_random_traffic(45);
      end
   endtask

   // ---------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------

   // receiver stalls; a requested hold takes precedence over random gaps
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off--;
      end else if (ready_gap > 0) begin
         rsp_ready <= 1'b0;
         ready_gap--;
      end else begin
         rsp_ready <= 1'b1;
         ready_gap = pick_gap();
      end
   end

   function automatic bit field_differs(string name, int unsigned want, int unsigned got);
      if (want != got && failures < 10)
         $display("tb: response %0d %s expected %0h got %0h", rsp_checked, name, want, got);
      return want != got;
   endfunction

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      bit      bad;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_dr_write, rsp_dr_byte, rsp_send_start, rsp_send_stop, rsp_clear_ack,
                rsp_led_update, rsp_led_axis, rsp_led_level, rsp_watchdog_kick,
                rsp_system_reset};
         if (expected_rsp_q.size() == 0) begin
            if (failures < 10)
               $display("tb: response %0d arrived with none outstanding", rsp_checked);
            failures++;
         end else begin
            want = expected_rsp_q.pop_front();
            bad  = 1'b0;
            bad |= field_differs("dr_write", want.dr_write, got.dr_write);
            bad |= field_differs("dr_byte", want.dr_byte, got.dr_byte);
            bad |= field_differs("send_start", want.send_start, got.send_start);
            bad |= field_differs("send_stop", want.send_stop, got.send_stop);
            bad |= field_differs("clear_ack", want.clear_ack, got.clear_ack);
            bad |= field_differs("led_update", want.led_update, got.led_update);
            bad |= field_differs("led_axis", want.led_axis, got.led_axis);
            bad |= field_differs("led_level", want.led_level, got.led_level);
            bad |= field_differs("watchdog_kick", want.watchdog_kick, got.watchdog_kick);
            bad |= field_differs("system_reset", want.system_reset, got.system_reset);
            if (bad)
               failures++;
         end
         rsp_checked++;
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: cycle limit reached, %0d responses outstanding",
                  expected_rsp_q.size());
         $display("tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin
      cfg_addr  = DEVICE_ADDRESS_RST;
      cfg_ctrl1 = CTRL1_INIT_RST;
      cfg_ctrl3 = CTRL3_INIT_RST;
      clear_sequencer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_config_sweep();
      test_random_traffic(1650);

      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("tb: %0d requests (start %0d, data ready %0d, bus status %0d, bus fault %0d)",
               requests_sent, kind_count[KIND_START], kind_count[KIND_DATA_RDY],
               kind_count[KIND_BUS_EVENT], kind_count[KIND_BUS_ERROR]);
      $display("tb: %0d responses checked, %0d LED levels, %0d kicks, %0d csr writes",
               rsp_checked, led_levels, wd_kicks, csr_writes);
      if (failures == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+design
design/aips_pkg.sv
design/aips_csr.sv
design/aips_ctrl.sv
design/accel_i2c_poll_sequencer.sv
test/tb.sv
